@@ rtl/core/alsfa_pkg.sv @@
// Package: types, constants and helpers for the feasible-ascent line search core.
`default_nettype none
package alsfa_pkg;
   localparam int Dims   = 8;
   localparam int Rows   = 32;
   localparam int Trials = 8;
   localparam int DimW   = $clog2(Dims);
   localparam int RowW   = $clog2(Rows);
   localparam int TrialW = $clog2(Trials);
   localparam int MemW   = RowW + DimW;

   typedef enum logic [2:0] {
      FUNC_MATRIX = 3'd0,
      FUNC_BOUND  = 3'd1,
      FUNC_COEFF  = 3'd2,
      FUNC_CENTER = 3'd3,
      FUNC_SEARCH = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CENTER, ST_TRIAL, ST_ROW, ST_OBJ, ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic             load;       // apply a load beat
      logic             start;      // latch search operands
      logic             acc_clear;  // zero accumulator
      logic             mac;        // one product into accumulator
      logic             mac_obj;    // product uses objective coefficient
      logic [DimW-1:0]  dim;
      logic [RowW-1:0]  row;
      logic [TrialW-1:0] trial;
      logic             trial_point; // use shifted axis coordinate
      logic             save_center;
      logic             row_check;   // compare accumulator to bound
      logic             obj_check;   // compare trial objective
      logic             finish;      // load output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic axis_ok;
      logic busy;       // checks still in the multiply-accumulate pipeline
   } stat_type;

   function automatic logic signed [63:0] sat_add(
      input logic signed [63:0] a, input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else sat_add = s[63:0];
   endfunction

   function automatic logic signed [4:0] trial_shift(input logic [TrialW-1:0] k);
      logic signed [7:0] kk;
      kk = 8'(k);
      if (kk < 8'(Trials / 2)) trial_shift = 5'(kk - 8'(Trials / 2));
      else trial_shift = 5'(kk - 8'(Trials / 2) + 8'sd1);
   endfunction
endpackage
`default_nettype wire

@@ rtl/core/alsfa_if.sv @@
// Interfaces: request, response and register write channels.
`default_nettype none
interface alsfa_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [4:0]  row;
   logic [2:0]  col;
   logic signed [31:0] value;
   logic [2:0]  axis;
   modport source(output valid, func, row, col, value, axis, input ready);
   modport sink(input valid, func, row, col, value, axis, output ready);
endinterface

interface alsfa_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [2:0]  best_slot;
   logic signed [3:0]  shift_amount;
   logic signed [31:0] new_coordinate;
   logic signed [63:0] best_objective;
   modport source(output valid, found, best_slot, shift_amount, new_coordinate,
      best_objective, input ready);
   modport sink(input valid, found, best_slot, shift_amount, new_coordinate,
      best_objective, output ready);
endinterface

interface alsfa_csr_if;
   logic        valid;
   logic        ready;
   logic [30:0] data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/alsfa_ctrl.sv @@
// Controller: takes load beats while idle and sequences the multiply-accumulate walk of a search.
`default_nettype none
module alsfa_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire logic [2:0] in_func,
   input  wire logic rsp_busy,
   input  wire alsfa_pkg::stat_type stat,
   output alsfa_pkg::cmd_type cmd
);
   alsfa_pkg::state_type state_ff, state_in;
   logic [alsfa_pkg::DimW-1:0]   dim_ff, dim_in;
   logic [alsfa_pkg::RowW-1:0]   row_ff, row_in;
   logic [alsfa_pkg::TrialW-1:0] trial_ff, trial_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alsfa_pkg::ST_IDLE;
         dim_ff   <= '0;
         row_ff   <= '0;
         trial_ff <= '0;
      end else begin
         state_ff <= state_in;
         dim_ff   <= dim_in;
         row_ff   <= row_in;
         trial_ff <= trial_in;
      end
   end

   always_comb begin
      logic last_dim;
      last_dim = (dim_ff == alsfa_pkg::DimW'(alsfa_pkg::Dims - 1));
      state_in = state_ff;
      dim_in   = dim_ff;
      row_in   = row_ff;
      trial_in = trial_ff;
      cmd      = '0;
      cmd.dim  = dim_ff;
      cmd.row  = row_ff;
      cmd.trial = trial_ff;
      in_ready = 1'b0;
      unique case (state_ff)
         alsfa_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               if (in_func == alsfa_pkg::FUNC_SEARCH) begin
                  cmd.start     = 1'b1;
                  cmd.acc_clear = 1'b1;
                  dim_in   = '0;
                  state_in = alsfa_pkg::ST_CENTER;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         alsfa_pkg::ST_CENTER: begin
            cmd.mac = 1'b1;
            cmd.mac_obj = 1'b1;
            dim_in = dim_ff + 1'b1;
            if (last_dim) begin
               cmd.save_center = 1'b1;
               trial_in = '0;
               row_in   = '0;
               dim_in   = '0;
               state_in = stat.axis_ok ? alsfa_pkg::ST_TRIAL : alsfa_pkg::ST_DONE;
            end
         end
         alsfa_pkg::ST_TRIAL: begin
            cmd.acc_clear = 1'b1;
            dim_in   = '0;
            state_in = alsfa_pkg::ST_ROW;
         end
         alsfa_pkg::ST_ROW: begin
            cmd.mac = 1'b1;
            cmd.trial_point = 1'b1;
            dim_in = dim_ff + 1'b1;
            if (last_dim) begin
               cmd.row_check = 1'b1;
               dim_in = '0;
               state_in = alsfa_pkg::ST_TRIAL;
               if (row_ff == alsfa_pkg::RowW'(alsfa_pkg::Rows - 1)) begin
                  row_in = '0;
                  state_in = alsfa_pkg::ST_OBJ;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         alsfa_pkg::ST_OBJ: begin
            cmd.mac = 1'b1;
            cmd.mac_obj = 1'b1;
            cmd.trial_point = 1'b1;
            dim_in = dim_ff + 1'b1;
            if (last_dim) begin
               cmd.obj_check = 1'b1;
               dim_in = '0;
               if (trial_ff == alsfa_pkg::TrialW'(alsfa_pkg::Trials - 1)) begin
                  state_in = alsfa_pkg::ST_DONE;
               end else begin
                  trial_in = trial_ff + 1'b1;
                  state_in = alsfa_pkg::ST_TRIAL;
               end
            end
         end
         alsfa_pkg::ST_DONE: begin
            // hold until the last check has landed and the output register is free
            if (!rsp_busy && !stat.busy) begin
               cmd.finish = 1'b1;
               state_in = alsfa_pkg::ST_IDLE;
            end
         end
         default: state_in = alsfa_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/core/alsfa_dp.sv @@
// Datapath: stores, shared multiply-accumulate, best-point tracking and output register.
`default_nettype none
module alsfa_dp (
   input  wire logic clock,
   input  wire logic reset,
   input  wire alsfa_pkg::cmd_type cmd,
   output alsfa_pkg::stat_type stat,
   input  wire logic [2:0] in_func,
   input  wire logic [4:0] in_row,
   input  wire logic [2:0] in_col,
   input  wire logic signed [31:0] in_value,
   input  wire logic [2:0] in_axis,
   input  wire logic csr_we,
   input  wire logic [30:0] csr_data,
   alsfa_rsp_if.source rsp
);
   localparam int Rows = alsfa_pkg::Rows;
   localparam int Dims = alsfa_pkg::Dims;
   localparam int DimW = alsfa_pkg::DimW;
   localparam int RowW = alsfa_pkg::RowW;

   // matrix memory with a written flag per entry, cleared only by reset
   logic signed [31:0] mat_mem [Rows*Dims];
   logic [Rows*Dims-1:0] mat_vld_ff;
   logic signed [31:0] bnd_ff [Rows];
   logic signed [31:0] coef_ff [Dims];
   logic signed [31:0] ctr_ff [Dims];
   logic [30:0] step_ff;

   logic [DimW-1:0] axis_ff;
   logic axis_ok_ff, infeas_ff, have_ff;
   logic signed [31:0] tcoord_ff;
   logic signed [63:0] acc_ff, cobj_ff, bobj_ff;
   logic [alsfa_pkg::TrialW-1:0] bslot_ff;
   logic signed [4:0] bshift_ff;
   logic signed [31:0] bcoord_ff;
   logic signed [31:0] mat_rd_ff, opa_ff, opb_ff;
   logic mat_vrd_ff, mul_vld_ff, prod_vld_ff;
   logic mul_obj_ff;
   logic signed [63:0] prod_ff;
   logic rsp_vld_ff;
   logic [alsfa_pkg::TrialW-1:0] trial_hold_ff;
   logic signed [31:0] coord_hold_ff;

   wire logic load_ok = cmd.load;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_vld_ff <= '0;
         for (int i = 0; i < Rows; i++) bnd_ff[i] <= '0;
         for (int j = 0; j < Dims; j++) begin
            coef_ff[j] <= '0;
            ctr_ff[j]  <= '0;
         end
         step_ff <= 31'd65536;
      end else begin
         if (csr_we) step_ff <= csr_data;
         if (load_ok) begin
            case (in_func)
               alsfa_pkg::FUNC_MATRIX:
                  mat_vld_ff[{in_row[RowW-1:0], in_col[DimW-1:0]}] <= 1'b1;
               alsfa_pkg::FUNC_BOUND:  bnd_ff[in_row[RowW-1:0]] <= in_value;
               alsfa_pkg::FUNC_COEFF:  coef_ff[in_col[DimW-1:0]] <= in_value;
               alsfa_pkg::FUNC_CENTER: ctr_ff[in_col[DimW-1:0]] <= in_value;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok && in_func == alsfa_pkg::FUNC_MATRIX)
         mat_mem[{in_row[RowW-1:0], in_col[DimW-1:0]}] <= in_value;
      mat_rd_ff  <= mat_mem[{cmd.row, cmd.dim}];
      mat_vrd_ff <= mat_vld_ff[{cmd.row, cmd.dim}];
   end

   // stage 1: operand select (matrix read in parallel), stage 2: multiply, stage 3: accumulate
   logic signed [31:0] pt_val;
   always_comb begin
      pt_val = ctr_ff[cmd.dim];
      if (cmd.trial_point && cmd.dim == axis_ff) pt_val = tcoord_ff;
   end

   logic [1:0] chk_row_d, chk_obj_d, save_d;
   logic signed [31:0] bnd_d1, bnd_d2;
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         chk_row_d <= '0;
         chk_obj_d <= '0;
         save_d <= '0;
      end else begin
         mul_vld_ff  <= cmd.mac;
         prod_vld_ff <= mul_vld_ff;
         chk_row_d   <= {chk_row_d[0], cmd.row_check};
         chk_obj_d   <= {chk_obj_d[0], cmd.obj_check};
         save_d      <= {save_d[0], cmd.save_center};
      end
      mul_obj_ff <= cmd.mac_obj;
      opa_ff <= cmd.mac_obj ? coef_ff[cmd.dim] : 32'sd0;
      opb_ff <= pt_val;
      bnd_d1 <= bnd_ff[cmd.row];
      bnd_d2 <= bnd_d1;
      prod_ff <= (mul_obj_ff ? opa_ff : (mat_vrd_ff ? mat_rd_ff : 32'sd0)) * opb_ff;
   end

   // clear the accumulator as each check lands; the next group's first product is later
   logic signed [63:0] acc_next;
   assign acc_next = alsfa_pkg::sat_add(acc_ff, prod_ff);

   logic signed [5:0] tsh;
   logic signed [64:0] tc_wide;
   logic [alsfa_pkg::TrialW-1:0] trial_use;
   assign trial_use = cmd.acc_clear && !cmd.start ? cmd.trial : cmd.trial;
   assign tsh = 6'(alsfa_pkg::trial_shift(trial_use));
   assign tc_wide = 65'(ctr_ff[axis_ff]) + 65'($signed({1'b0, step_ff})) * 65'(tsh);

   // a check lands through its delay line in the same cycle as the final product of its group
   logic signed [63:0] acc_final;
   assign acc_final = prod_vld_ff ? acc_next : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         have_ff <= 1'b0;
         infeas_ff <= 1'b0;
         axis_ok_ff <= 1'b0;
      end else begin
         if (cmd.start || chk_row_d[1] || chk_obj_d[1] || save_d[1]) acc_ff <= '0;
         else if (prod_vld_ff) acc_ff <= acc_next;
         if (cmd.start) begin
            axis_ok_ff <= (4'(in_axis) < 4'(Dims));
            have_ff <= 1'b0;
            infeas_ff <= 1'b0;
         end
         // the objective check closes a trial, so the next one starts feasible
         if (chk_obj_d[1]) infeas_ff <= 1'b0;
         if (chk_row_d[1] && acc_final > ($signed({bnd_d2, 16'd0}) >>> 0) )
            infeas_ff <= 1'b1;
         if (chk_obj_d[1] && !infeas_ff && acc_final > cobj_ff &&
             (!have_ff || acc_final > bobj_ff)) begin
            have_ff <= 1'b1;
         end
         if (rsp.valid && rsp.ready) rsp_vld_ff <= 1'b0;
         if (cmd.finish) rsp_vld_ff <= 1'b1;
      end
      if (cmd.start) axis_ff <= in_axis[DimW-1:0];
      if (cmd.acc_clear && !cmd.start) begin
         if (tc_wide > 65'sd2147483647) tcoord_ff <= 32'sh7fffffff;
         else if (tc_wide < -65'sd2147483648) tcoord_ff <= 32'sh80000000;
         else tcoord_ff <= tc_wide[31:0];
      end
      if (save_d[1]) begin
         cobj_ff <= acc_final;
         bobj_ff <= acc_final;
         bcoord_ff <= axis_ok_ff ? ctr_ff[axis_ff] : 32'sd0;
         bslot_ff <= '0;
         bshift_ff <= '0;
      end
      if (chk_obj_d[1] && !infeas_ff && acc_final > cobj_ff &&
          (!have_ff || acc_final > bobj_ff)) begin
         bobj_ff <= acc_final;
         bslot_ff <= trial_hold_ff;
         bshift_ff <= alsfa_pkg::trial_shift(trial_hold_ff);
         bcoord_ff <= coord_hold_ff;
      end
      if (cmd.finish) begin
         rsp.found <= have_ff;
         rsp.best_slot <= 3'(bslot_ff);
         rsp.shift_amount <= bshift_ff[3:0];
         rsp.new_coordinate <= bcoord_ff;
         rsp.best_objective <= bobj_ff;
      end
   end

   // hold the trial's slot and coordinate until its objective check lands
   always_ff @(posedge clock) begin
      if (cmd.obj_check) begin
         trial_hold_ff <= cmd.trial;
         coord_hold_ff <= tcoord_ff;
      end
   end

   assign rsp.valid = rsp_vld_ff;
   assign stat.axis_ok = axis_ok_ff;
   assign stat.busy = (|chk_row_d) || (|chk_obj_d) || (|save_d);
endmodule
`default_nettype wire

@@ rtl/core/axis_line_search_feasible_ascent_core.sv @@
// Top level: feasible-ascent line search along one axis.
// A search computes the centre objective, then for each trial every row check and the trial
// objective in turn, all through the one shared multiply-accumulate unit.
// Throughput: one search at a time; loads are taken one per cycle while idle.
// Reset (synchronous): all stores zero, step 1.0, no response pending.
`default_nettype none
module axis_line_search_feasible_ascent_core (
   input wire logic clock,
   input wire logic reset,
   alsfa_req_if.sink   req,
   alsfa_rsp_if.source rsp,
   alsfa_csr_if.sink   csr
);
   alsfa_pkg::cmd_type  cmd;
   alsfa_pkg::stat_type stat;

   assign csr.ready = 1'b1;

   alsfa_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_func(req.func),
      .rsp_busy(rsp.valid && !rsp.ready), .stat, .cmd
   );

   alsfa_dp u_dp (
      .clock, .reset, .cmd, .stat,
      .in_func(req.func), .in_row(req.row), .in_col(req.col),
      .in_value(req.value), .in_axis(req.axis),
      .csr_we(csr.valid), .csr_data(csr.data), .rsp
   );
endmodule
`default_nettype wire

@@ rtl/core/alsfa_checker.sv @@
// Port checker for the line search core, bound to the top level.
`default_nettype none
module alsfa_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid, req_ready,
   input wire logic rsp_valid, rsp_ready,
   input wire logic [2:0] req_func,
   input wire logic found,
   input wire logic [2:0] best_slot,
   input wire logic signed [3:0] shift_amount
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_no_shift: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !found |-> shift_amount == 4'sd0 && best_slot == 3'd0)
      else $error("shift without find");
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == alsfa_pkg::FUNC_SEARCH |=> !req_ready)
      else $error("accepted during search");
   a_found_shift: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && found |-> shift_amount != 4'sd0) else $error("zero shift found");
endmodule

bind axis_line_search_feasible_ascent_core alsfa_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .req_func(req.func),
   .found(rsp.found), .best_slot(rsp.best_slot), .shift_amount(rsp.shift_amount)
);
`default_nettype wire
